// ===== design/phc_pkg.sv =====
package phc_pkg;

  // Register index width of the source and destination fields
  localparam int unsigned REG_INDEX_BITS = 4;

  // Branch sequencer cycle count, saturating
  localparam int unsigned BR_CNT_BITS = 2;
  localparam logic [BR_CNT_BITS-1:0] BR_CNT_MAX    = 2'd3;
  localparam logic [BR_CNT_BITS-1:0] BR_CNT_FIRST  = 2'd1;
  localparam logic [BR_CNT_BITS-1:0] BR_CNT_SECOND = 2'd2;

  typedef logic [REG_INDEX_BITS-1:0] reg_idx_t;

  // One pipeline-cycle status request
  typedef struct packed {
    logic     instr_ready;
    logic     cache_request;
    logic     cache_ready;
    logic     seg_fault;
    logic     branch_cond_early;
    logic     branch_cond_writeback;
    reg_idx_t source_a;
    reg_idx_t source_b;
    reg_idx_t execute_dest;
    reg_idx_t memory_dest;
    logic     branch_in_execute;
  } item_t;

  // Stall, flush and acknowledge controls for one cycle
  typedef struct packed {
    logic stall_fetch;
    logic stall_decode;
    logic stall_execute;
    logic stall_memory;
    logic stall_writeback;
    logic flush_decode;
    logic flush_execute;
    logic cache_ack;
  } result_t;

  // Handshake and branch sequencer state
  typedef struct packed {
    logic                   mem_busy;
    logic                   ack_given;
    logic                   branch_active;
    logic [BR_CNT_BITS-1:0] branch_count;
    logic                   branch_wait_wb;
  } state_t;

  // Read-after-write match; register zero never hazards
  function automatic logic reads_from(input reg_idx_t src, input reg_idx_t dst);
    reads_from = (src != '0) && (dst != '0) && (src == dst);
  endfunction

endpackage

// ===== design/phc_decide.sv =====
module phc_decide import phc_pkg::*; (
  input  item_t   item_i,
  input  state_t  state_i,
  output result_t result_o,
  output state_t  state_o
);

  logic mstall;
  logic hazard;

  assign hazard = reads_from(item_i.source_a, item_i.execute_dest) ||
                  reads_from(item_i.source_a, item_i.memory_dest)  ||
                  reads_from(item_i.source_b, item_i.execute_dest) ||
                  reads_from(item_i.source_b, item_i.memory_dest);

  // Priority decision: fault, missing instruction, cache, hazard, branch
  always_comb begin
    result_o = '0;
    state_o  = state_i;
    mstall   = 1'b0;
    if (item_i.seg_fault) begin
      result_o.stall_fetch     = 1'b1;
      result_o.stall_decode    = 1'b1;
      result_o.stall_execute   = 1'b1;
      result_o.stall_memory    = 1'b1;
      result_o.stall_writeback = 1'b1;
    end else if (!item_i.instr_ready) begin
      result_o.stall_fetch  = 1'b1;
      result_o.stall_decode = 1'b1;
    end else begin
      // cache ready/acknowledge handshake
      if (item_i.cache_request) begin
        if (!state_i.mem_busy) begin
          state_o.mem_busy  = 1'b1;
          state_o.ack_given = 1'b0;
        end
        if (!state_o.ack_given) begin
          if (item_i.cache_ready) begin
            state_o.ack_given  = 1'b1;
            result_o.cache_ack = 1'b1;
          end
          mstall = 1'b1;
        end else if (item_i.cache_ready) begin
          result_o.cache_ack = 1'b1;
          mstall             = 1'b1;
        end else begin
          state_o.mem_busy  = 1'b0;
          state_o.ack_given = 1'b0;
        end
      end else begin
        state_o.mem_busy  = 1'b0;
        state_o.ack_given = 1'b0;
      end

      if (mstall) begin
        result_o.stall_fetch     = 1'b1;
        result_o.stall_decode    = 1'b1;
        result_o.stall_execute   = 1'b1;
        result_o.stall_memory    = 1'b1;
        result_o.stall_writeback = 1'b1;
      end else if (hazard) begin
        result_o.stall_fetch   = 1'b1;
        result_o.stall_decode  = 1'b1;
        result_o.flush_execute = 1'b1;
      end else begin
        // branch sequencer
        if (item_i.branch_in_execute && !state_i.branch_active) begin
          state_o.branch_active  = 1'b1;
          state_o.branch_count   = '0;
          state_o.branch_wait_wb = 1'b0;
        end
        if (state_o.branch_active) begin
          if (state_o.branch_count != BR_CNT_MAX) begin
            state_o.branch_count = state_o.branch_count + BR_CNT_BITS'(1);
          end
          if (state_o.branch_count == BR_CNT_FIRST) begin
            result_o.stall_fetch  = 1'b1;
            result_o.flush_decode = 1'b1;
          end else if (state_o.branch_count == BR_CNT_SECOND) begin
            if (item_i.branch_cond_early) begin
              result_o.stall_fetch   = 1'b1;
              result_o.flush_decode  = 1'b1;
              state_o.branch_wait_wb = 1'b1;
            end else begin
              state_o.branch_active = 1'b0;
            end
          end else if (state_o.branch_wait_wb) begin
            result_o.flush_decode = 1'b1;
            if (item_i.branch_cond_writeback) begin
              state_o.branch_wait_wb = 1'b0;
              state_o.branch_active  = 1'b0;
            end else begin
              result_o.stall_fetch = 1'b1;
            end
          end else begin
            state_o.branch_active = 1'b0;
          end
        end
      end
    end
  end

endmodule

// ===== design/phc_state.sv =====
module phc_state import phc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   commit_i,
  input  state_t state_i,
  output state_t state_o
);

  state_t state_q;

  // State advances once per request leaving the decision stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (commit_i) begin
      state_q <= state_i;
    end
  end

  assign state_o = state_q;

  a_ack_needs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.ack_given |-> state_q.mem_busy)
    else $error("ack_given set outside a cache access");

  a_wait_needs_branch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.branch_wait_wb |-> state_q.branch_active)
    else $error("writeback wait set with no branch running");

  a_hold_no_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !commit_i |=> $stable(state_q))
    else $error("state changed without a commit");

endmodule

// ===== design/pipeline_hazard_controller_top.sv =====
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i / in_stall_o | status fields, one port each
// out     | output    | out_valid_o / out_stall_i | stall, flush and ack fields
//
// Each request passes an input register, is decided by combinational logic
// and lands in the result register; one request per cycle is sustained
// while the receiver does not stall the output.
// Reset clears the valid flags and the handshake and branch state.
// A stalled result holds in the result register while the input register
// takes a request only if empty; state is committed as each result is loaded.
module pipeline_hazard_controller_top import phc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  logic     instr_ready_i,
  input  logic     cache_request_i,
  input  logic     cache_ready_i,
  input  logic     seg_fault_i,
  input  logic     branch_cond_early_i,
  input  logic     branch_cond_writeback_i,
  input  reg_idx_t source_a_i,
  input  reg_idx_t source_b_i,
  input  reg_idx_t execute_dest_i,
  input  reg_idx_t memory_dest_i,
  input  logic     branch_in_execute_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output logic     stall_fetch_o,
  output logic     stall_decode_o,
  output logic     stall_execute_o,
  output logic     stall_memory_o,
  output logic     stall_writeback_o,
  output logic     flush_decode_o,
  output logic     flush_execute_o,
  output logic     cache_ack_o
);

  item_t   item_in;
  item_t   item_q;
  logic    item_valid_q;
  logic    advance;
  logic    commit;
  result_t result_d;
  result_t result_q;
  logic    result_valid_q;
  state_t  state_q;
  state_t  state_d;

  assign item_in = '{
    instr_ready:           instr_ready_i,
    cache_request:         cache_request_i,
    cache_ready:           cache_ready_i,
    seg_fault:             seg_fault_i,
    branch_cond_early:     branch_cond_early_i,
    branch_cond_writeback: branch_cond_writeback_i,
    source_a:              source_a_i,
    source_b:              source_b_i,
    execute_dest:          execute_dest_i,
    memory_dest:           memory_dest_i,
    branch_in_execute:     branch_in_execute_i
  };

  // Stage moves when the result register is empty or being taken
  assign advance    = !result_valid_q || !out_stall_i;
  assign commit     = item_valid_q && advance;
  assign in_stall_o = item_valid_q && !advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= item_in;
    end
  end

  phc_decide u_decide (
    .item_i   (item_q),
    .state_i  (state_q),
    .result_o (result_d),
    .state_o  (state_d)
  );

  phc_state u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (commit),
    .state_i  (state_d),
    .state_o  (state_q)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else if (advance) begin
      result_valid_q <= item_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o       = result_valid_q;
  assign stall_fetch_o     = result_q.stall_fetch;
  assign stall_decode_o    = result_q.stall_decode;
  assign stall_execute_o   = result_q.stall_execute;
  assign stall_memory_o    = result_q.stall_memory;
  assign stall_writeback_o = result_q.stall_writeback;
  assign flush_decode_o    = result_q.flush_decode;
  assign flush_execute_o   = result_q.flush_execute;
  assign cache_ack_o       = result_q.cache_ack;

  a_ack_stalls_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cache_ack_o |-> stall_fetch_o && stall_decode_o &&
      stall_execute_o && stall_memory_o && stall_writeback_o)
    else $error("cache acknowledge without a full stall");

  a_flush_ex_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && flush_execute_o |-> stall_fetch_o && stall_decode_o &&
      !stall_execute_o && !flush_decode_o && !cache_ack_o)
    else $error("hazard result malformed");

  a_commit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_o)
    else $error("committed request lost before result register");

endmodule

// ===== test/tb_pipeline_hazard_controller_top.sv =====
`timescale 1ns / 1ps

module tb_pipeline_hazard_controller_top;
  import phc_pkg::*;

  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_OFF_CYCLES = 60;

  // Kinds of random traffic
  typedef enum int unsigned {
    EP_CACHE,
    EP_BRANCH,
    EP_HAZARD,
    EP_NOISE
  } episode_e;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  logic     instr_ready_i = 1'b0;
  logic     cache_request_i = 1'b0;
  logic     cache_ready_i = 1'b0;
  logic     seg_fault_i = 1'b0;
  logic     branch_cond_early_i = 1'b0;
  logic     branch_cond_writeback_i = 1'b0;
  reg_idx_t source_a_i = '0;
  reg_idx_t source_b_i = '0;
  reg_idx_t execute_dest_i = '0;
  reg_idx_t memory_dest_i = '0;
  logic     branch_in_execute_i = 1'b0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  logic     stall_fetch_o;
  logic     stall_decode_o;
  logic     stall_execute_o;
  logic     stall_memory_o;
  logic     stall_writeback_o;
  logic     flush_decode_o;
  logic     flush_execute_o;
  logic     cache_ack_o;

  // Shared stimulus and scoreboard state
  state_t      ctrl_state;
  result_t     expected_controls [$];
  int unsigned mismatch_count = 0;
  int unsigned requests_sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_request = 0;

  // Field names, indexed by bit position in result_t
  string field_name [0:7] = '{"cache_ack", "flush_execute", "flush_decode",
                              "stall_writeback", "stall_memory", "stall_execute",
                              "stall_decode", "stall_fetch"};

  pipeline_hazard_controller_top uut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .instr_ready_i          (instr_ready_i),
    .cache_request_i        (cache_request_i),
    .cache_ready_i          (cache_ready_i),
    .seg_fault_i            (seg_fault_i),
    .branch_cond_early_i    (branch_cond_early_i),
    .branch_cond_writeback_i(branch_cond_writeback_i),
    .source_a_i             (source_a_i),
    .source_b_i             (source_b_i),
    .execute_dest_i         (execute_dest_i),
    .memory_dest_i          (memory_dest_i),
    .branch_in_execute_i    (branch_in_execute_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .stall_fetch_o          (stall_fetch_o),
    .stall_decode_o         (stall_decode_o),
    .stall_execute_o        (stall_execute_o),
    .stall_memory_o         (stall_memory_o),
    .stall_writeback_o      (stall_writeback_o),
    .flush_decode_o         (flush_decode_o),
    .flush_execute_o        (flush_execute_o),
    .cache_ack_o            (cache_ack_o)
  );

  // 12 ns clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("ERROR at %0t: %s expected %0d got %0d", $time, what, want, got);
    mismatch_count++;
  endtask

  // Source depends on a pending write; register zero never matches
  function automatic logic depends_on(input reg_idx_t src, input reg_idx_t dst);
    return (src != '0) && (src == dst);
  endfunction

  // Decide the controls for one request and advance the tracked state
  task automatic predict_controls(input item_t it, output result_t r);
    logic mem_hold;
    r = '0;
    mem_hold = 1'b0;
    if (it.seg_fault) begin
      {r.stall_fetch, r.stall_decode, r.stall_execute} = 3'b111;
      {r.stall_memory, r.stall_writeback} = 2'b11;
    end else if (!it.instr_ready) begin
      r.stall_fetch = 1'b1;
      r.stall_decode = 1'b1;
    end else begin
      // cache ready/acknowledge handshake
      if (it.cache_request) begin
        if (!ctrl_state.mem_busy) begin
          ctrl_state.mem_busy = 1'b1;
          ctrl_state.ack_given = 1'b0;
        end
        if (!ctrl_state.ack_given) begin
          if (it.cache_ready) begin
            ctrl_state.ack_given = 1'b1;
            r.cache_ack = 1'b1;
          end
          mem_hold = 1'b1;
        end else if (it.cache_ready) begin
          r.cache_ack = 1'b1;
          mem_hold = 1'b1;
        end else begin
          ctrl_state.mem_busy = 1'b0;
          ctrl_state.ack_given = 1'b0;
        end
      end else begin
        ctrl_state.mem_busy = 1'b0;
        ctrl_state.ack_given = 1'b0;
      end

      if (mem_hold) begin
        {r.stall_fetch, r.stall_decode, r.stall_execute} = 3'b111;
        {r.stall_memory, r.stall_writeback} = 2'b11;
      end else if (depends_on(it.source_a, it.execute_dest) ||
                   depends_on(it.source_a, it.memory_dest) ||
                   depends_on(it.source_b, it.execute_dest) ||
                   depends_on(it.source_b, it.memory_dest)) begin
        r.stall_fetch = 1'b1;
        r.stall_decode = 1'b1;
        r.flush_execute = 1'b1;
      end else begin
        // branch sequencer
        if (it.branch_in_execute && !ctrl_state.branch_active) begin
          ctrl_state.branch_active = 1'b1;
          ctrl_state.branch_count = '0;
          ctrl_state.branch_wait_wb = 1'b0;
        end
        if (ctrl_state.branch_active) begin
          if (ctrl_state.branch_count != BR_CNT_MAX)
            ctrl_state.branch_count = ctrl_state.branch_count + BR_CNT_BITS'(1);
          if (ctrl_state.branch_count == BR_CNT_FIRST) begin
            r.stall_fetch = 1'b1;
            r.flush_decode = 1'b1;
          end else if (ctrl_state.branch_count == BR_CNT_SECOND) begin
            if (it.branch_cond_early) begin
              r.stall_fetch = 1'b1;
              r.flush_decode = 1'b1;
              ctrl_state.branch_wait_wb = 1'b1;
            end else begin
              ctrl_state.branch_active = 1'b0;
            end
          end else if (ctrl_state.branch_wait_wb) begin
            r.flush_decode = 1'b1;
            if (it.branch_cond_writeback) begin
              ctrl_state.branch_wait_wb = 1'b0;
              ctrl_state.branch_active = 1'b0;
            end else begin
              r.stall_fetch = 1'b1;
            end
          end else begin
            ctrl_state.branch_active = 1'b0;
          end
        end
      end
    end
  endtask

  // Offer one request, hold it until accepted, then record what it should give
  task automatic send_request(input item_t it);
    result_t want;
    @(negedge clk_i);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    instr_ready_i           <= it.instr_ready;
    cache_request_i         <= it.cache_request;
    cache_ready_i           <= it.cache_ready;
    seg_fault_i             <= it.seg_fault;
    branch_cond_early_i     <= it.branch_cond_early;
    branch_cond_writeback_i <= it.branch_cond_writeback;
    source_a_i              <= it.source_a;
    source_b_i              <= it.source_b;
    execute_dest_i          <= it.execute_dest;
    memory_dest_i           <= it.memory_dest;
    branch_in_execute_i     <= it.branch_in_execute;
    in_valid_i              <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predict_controls(it, want);
    expected_controls.push_back(want);
    requests_sent++;
  endtask

  task automatic release_sender();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  function automatic item_t make_status(input logic ir, input logic creq, input logic crdy,
                                        input logic flt, input logic early, input logic wb,
                                        input reg_idx_t sa, input reg_idx_t sb,
                                        input reg_idx_t ed, input reg_idx_t md,
                                        input logic br);
    item_t it;
    it.instr_ready = ir;
    it.cache_request = creq;
    it.cache_ready = crdy;
    it.seg_fault = flt;
    it.branch_cond_early = early;
    it.branch_cond_writeback = wb;
    it.source_a = sa;
    it.source_b = sb;
    it.execute_dest = ed;
    it.memory_dest = md;
    it.branch_in_execute = br;
    return it;
  endfunction

  // Well-formed cycle: instruction present, no fault, no cache access, no branch, rarely a hazard
  function automatic item_t clean_status();
    item_t it;
    it = item_t'($urandom);
    it.instr_ready = 1'b1;
    it.seg_fault = 1'b0;
    it.cache_request = 1'b0;
    it.branch_in_execute = 1'b0;
    if ($urandom_range(3) != 0) begin
      it.execute_dest = '0;
      it.memory_dest = '0;
    end
    return it;
  endfunction

  // Occasionally knock a sequence off course with a fault or a missing instruction
  function automatic item_t maybe_disrupt(input item_t it);
    item_t r;
    r = it;
    if ($urandom_range(9) == 0) begin
      if ($urandom_range(1) != 0) r.seg_fault = 1'b1;
      else r.instr_ready = 1'b0;
    end
    return r;
  endfunction

  task automatic send_cache_episode();
    item_t it;
    int unsigned wait_n;
    int unsigned rdy_n;
    wait_n = $urandom_range(0, 3);
    rdy_n = $urandom_range(1, 3);
    for (int i = 0; i < wait_n; i++) begin
      it = clean_status();
      it.cache_request = 1'b1;
      it.cache_ready = 1'b0;
      send_request(maybe_disrupt(it));
    end
    for (int i = 0; i < rdy_n; i++) begin
      it = clean_status();
      it.cache_request = 1'b1;
      it.cache_ready = 1'b1;
      send_request(maybe_disrupt(it));
    end
    // ready drops: handshake ends and the lower steps decide
    it = clean_status();
    it.cache_request = $urandom_range(3) != 0;
    it.cache_ready = 1'b0;
    send_request(it);
  endtask

  task automatic send_branch_episode();
    item_t it;
    int unsigned len;
    len = $urandom_range(2, 6);
    it = clean_status();
    it.branch_in_execute = 1'b1;
    send_request(it);
    for (int i = 0; i < len; i++) begin
      it = clean_status();
      it.branch_in_execute = $urandom_range(4) == 0;
      it.branch_cond_writeback = $urandom_range(2) == 0;
      send_request(maybe_disrupt(it));
    end
  endtask

  task automatic send_hazard();
    item_t it;
    reg_idx_t r;
    r = reg_idx_t'($urandom_range(1, (1 << REG_INDEX_BITS) - 1));
    it = clean_status();
    it.branch_in_execute = 1'($urandom_range(1));
    if ($urandom_range(1) != 0) it.source_a = r;
    else it.source_b = r;
    if ($urandom_range(1) != 0) it.execute_dest = r;
    else it.memory_dest = r;
    send_request(it);
  endtask

  // Directed: each decision step, the handshake and branch sequences, field extremes
  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_request(make_status(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                             4'd0, 4'd0, 4'd0, 4'd0, 1'b0));
    send_request(make_status(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
                             4'd15, 4'd15, 4'd15, 4'd15, 1'b1));
    send_request(make_status(1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1,
                             4'd15, 4'd15, 4'd15, 4'd15, 1'b0));
    // cache handshake: wait, ack, ack held, fault and missing instruction in between, ready drop, idle
    send_request(make_status(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                             4'd1, 4'd2, 4'd0, 4'd0, 1'b0));
    send_request(make_status(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0,
                             4'd1, 4'd2, 4'd0, 4'd0, 1'b0));
    send_request(make_status(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0,
                             4'd1, 4'd2, 4'd0, 4'd0, 1'b0));
    send_request(make_status(1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0,
                             4'd1, 4'd2, 4'd0, 4'd0, 1'b0));
    send_request(make_status(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                             4'd1, 4'd2, 4'd0, 4'd0, 1'b0));
    send_request(make_status(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                             4'd1, 4'd2, 4'd3, 4'd0, 1'b0));
    send_request(make_status(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                             4'd1, 4'd2, 4'd3, 4'd0, 1'b0));
    // hazards on each source/destination pair, and register zero
    send_request(make_status(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                             4'd5, 4'd6, 4'd5, 4'd9, 1'b0));
    send_request(make_status(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                             4'd5, 4'd6, 4'd9, 4'd5, 1'b0));
    send_request(make_status(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                             4'd7, 4'd8, 4'd8, 4'd9, 1'b0));
    send_request(make_status(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                             4'd7, 4'd8, 4'd9, 4'd8, 1'b0));
    send_request(make_status(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                             4'd0, 4'd0, 4'd0, 4'd0, 1'b0));
    // taken early branch, a hazard mid-sequence, writeback confirms late
    send_request(make_status(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                             4'd1, 4'd2, 4'd0, 4'd0, 1'b1));
    send_request(make_status(1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0,
                             4'd1, 4'd2, 4'd0, 4'd0, 1'b0));
    send_request(make_status(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                             4'd3, 4'd2, 4'd3, 4'd0, 1'b1));
    send_request(make_status(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                             4'd1, 4'd2, 4'd0, 4'd0, 1'b1));
    send_request(make_status(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                             4'd1, 4'd2, 4'd0, 4'd0, 1'b0));
    // not-taken branch ends when the early condition is found clear
    send_request(make_status(1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
                             4'd1, 4'd2, 4'd0, 4'd0, 1'b1));
    send_request(make_status(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                             4'd1, 4'd2, 4'd0, 4'd0, 1'b1));
    send_request(make_status(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                             4'd1, 4'd2, 4'd0, 4'd0, 1'b0));
    release_sender();
  endtask

  // Random traffic, mostly well-formed sequences, under a given idling mix
  task automatic test_random_phase(input int unsigned n, input int unsigned idle_pct,
                                   input int unsigned stall_pct);
    int unsigned target;
    episode_e ep;
    target = requests_sent + n;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    while (requests_sent < target) begin
      case ($urandom_range(9))
        0, 1, 2: ep = EP_CACHE;
        3, 4, 5: ep = EP_BRANCH;
        6:       ep = EP_HAZARD;
        default: ep = EP_NOISE;
      endcase
      case (ep)
        EP_CACHE:  send_cache_episode();
        EP_BRANCH: send_branch_episode();
        EP_HAZARD: send_hazard();
        default:   send_request(item_t'($urandom));
      endcase
    end
    release_sender();
  endtask

  // Receiver holds off for a long stretch while requests keep coming
  task automatic test_back_pressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = HOLD_OFF_CYCLES;
    for (int i = 0; i < 30; i++) begin
      send_request(clean_status());
    end
    release_sender();
  endtask

  // Receiver: random stalls, or a counted hold-off when one is asked for
  always @(negedge clk_i) begin : receiver
    int unsigned hold_left;
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct;
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin : check_results
    result_t got;
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {stall_fetch_o, stall_decode_o, stall_execute_o, stall_memory_o,
             stall_writeback_o, flush_decode_o, flush_execute_o, cache_ack_o};
      if (expected_controls.size() == 0) begin
        report_mismatch("result with nothing outstanding", 0, 1);
      end else begin
        want = expected_controls.pop_front();
        for (int b = 0; b < $bits(result_t); b++) begin
          if (got[b] !== want[b]) report_mismatch(field_name[b], want[b], got[b]);
        end
      end
    end
  end

  // Watchdog: too long without either channel moving
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet = 0;
      else
        quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    ctrl_state = '0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random_phase(400, 0, 0);
    test_random_phase(400, 73, 0);
    test_random_phase(400, 0, 73);
    test_random_phase(400, 13, 13);
    test_back_pressure();

    // drain, then let the pipeline settle
    recv_stall_pct = 0;
    while (expected_controls.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_controls.size() != 0)
      report_mismatch("results still outstanding", 0, expected_controls.size());

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
